[rtl/hrs_pkg.sv]
// Shared types and constants for the HID report splitter.
`default_nettype none

package hrs_pkg;

   // Default payload bytes carried by one report.
   localparam int PAYLOAD_LEN_DEFAULT = 58;

   // Header bytes in front of the payload: index, total and length.
   localparam int HEADER_LEN = 6;

   // Width of the message length field.
   localparam int LENGTH_W = 16;

   // Width of the capacity register and its limit and reset value.
   localparam int CAP_W = 9;
   localparam logic [CAP_W-1:0] CAP_LIMIT = 9'd256;

   // Input item commands.
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } command_type;

   // Result item kinds.
   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   // Status codes carried by a status result.
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ZERO_LENGTH = 2'd1,
      STATUS_TOO_MANY    = 2'd2,
      STATUS_NO_MESSAGE  = 2'd3
   } status_type;

endpackage

`default_nettype wire

[rtl/hrs_divider.sv]
// Division by a constant through a registered reciprocal multiplication.
`default_nettype none

module hrs_divider #(
   parameter int NUM_W   = hrs_pkg::LENGTH_W + 1,
   parameter int DIVISOR = hrs_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   // The reciprocal is rounded up; its error times the largest dividend stays
   // below one unit of the shift, so the truncated product is the exact quotient.
   localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
   localparam int MULT_W = SHIFT + 1;
   localparam int PROD_W = NUM_W + MULT_W;
   localparam logic [MULT_W-1:0] MULT =
      MULT_W'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

   logic             done_ff;
   logic [NUM_W-1:0] quo_ff;

   // Done rises in the cycle after start, together with the quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Multiply by the reciprocal and keep the integer part.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= NUM_W'((PROD_W'(dividend) * PROD_W'(MULT)) >> SHIFT);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/hid_report_splitter_core.sv]
// Top level of the HID report splitter: command decode, payload buffer and report streaming.
`default_nettype none

// A start item opens a message of a given byte length. The report count, the length
// divided by PAYLOAD_LEN and rounded up, comes from a reciprocal multiplication that is
// registered in the divider; the status item then passes through the status state into
// the output register, and the next item is taken once it is loaded there. A data item
// that neither fills the buffer nor ends the message does not hold off the next item and
// is stored in the payload buffer at the fill position. When it fills the buffer or ends
// the message, the block streams one report of HEADER_LEN + PAYLOAD_LEN bytes (64 by
// default) at one byte per cycle while rsp_ready does not stall it, through a read
// pipeline on the buffer memory; the next item is taken once the last report byte has
// been loaded into the output register. A data item with no open message returns a
// status item, and the next item is taken once it is loaded into the output register.
// A result held back by rsp_ready stalls the report stream and the status state until it is taken.

module hid_report_splitter_core #(
   parameter int PAYLOAD_LEN = hrs_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_command,
   input  wire logic [hrs_pkg::LENGTH_W-1:0]  req_message_length,
   input  wire logic [7:0]                    req_data_byte,
   // Result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic [1:0]                         rsp_status,
   output logic [7:0]                         rsp_report_byte,
   output logic                               rsp_last_of_report,
   // Configuration port
   input  wire logic                          csr_write_enable,
   input  wire logic [hrs_pkg::CAP_W-1:0]     csr_write_data
);

   localparam int LENGTH_W   = hrs_pkg::LENGTH_W;
   localparam int CAP_W      = hrs_pkg::CAP_W;
   localparam int REPORT_LEN = hrs_pkg::HEADER_LEN + PAYLOAD_LEN;
   localparam int IDX_W      = $clog2(REPORT_LEN);
   localparam int ADDR_W     = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
   localparam int FILL_W     = $clog2(PAYLOAD_LEN + 1);
   localparam int NUM_W      = LENGTH_W + 1;

   // Header byte positions within a report.
   localparam logic [IDX_W-1:0] HDR_NUMBER_HI = IDX_W'(0);
   localparam logic [IDX_W-1:0] HDR_NUMBER_LO = IDX_W'(1);
   localparam logic [IDX_W-1:0] HDR_TOTAL_HI  = IDX_W'(2);
   localparam logic [IDX_W-1:0] HDR_TOTAL_LO  = IDX_W'(3);
   localparam logic [IDX_W-1:0] HDR_FILL_HI   = IDX_W'(4);
   localparam logic [IDX_W-1:0] HDR_FILL_LO   = IDX_W'(5);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STATUS,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [CAP_W-1:0]     max_blocks_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [15:0]          block_number_ff;
   logic [CAP_W-1:0]     block_total_ff;
   logic [LENGTH_W-1:0]  remaining_ff;
   logic                 open_ff;
   logic [LENGTH_W-1:0]  length_ff;
   hrs_pkg::status_type  pend_status_ff;
   logic [IDX_W-1:0]     idx_ff;

   // Read stage between the buffer memory and the output register.
   logic                 b_valid_ff;
   logic                 b_use_mem_ff;
   logic                 b_last_ff;
   logic [7:0]           b_hdr_ff;
   logic [7:0]           rd_data_ff;

   // Output register.
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [1:0]           rsp_status_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;

   // Payload buffer.
   logic [7:0]           payload_mem [PAYLOAD_LEN];

   logic                 req_accept;
   logic                 out_free;
   logic                 issue;
   logic [IDX_W-1:0]     pay_idx;
   logic                 use_mem;
   logic                 last_idx;
   logic [15:0]          fill_word;
   logic [7:0]           hdr_byte;
   logic [FILL_W-1:0]    fill_inc;
   logic [LENGTH_W-1:0]  remain_dec;
   logic                 report_due;
   logic [CAP_W-1:0]     cap;
   logic [NUM_W-1:0]     dividend;
   logic                 div_done;
   logic [NUM_W-1:0]     blocks;
   logic                 too_many;
   logic                 mem_write;
   logic                 mem_read;

   // Handshake and pipeline advance.
   assign req_ready  = (state_ff == ST_IDLE) && !b_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign issue      = (state_ff == ST_EMIT) && out_free;

   // Report byte selection for the position being issued.
   assign pay_idx   = idx_ff - IDX_W'(hrs_pkg::HEADER_LEN);
   assign use_mem   = (idx_ff >= IDX_W'(hrs_pkg::HEADER_LEN)) &&
                      (pay_idx < IDX_W'(fill_ff));
   assign last_idx  = idx_ff == IDX_W'(REPORT_LEN - 1);
   assign fill_word = 16'(fill_ff);

   always_comb begin
      case (idx_ff)
         HDR_NUMBER_HI: hdr_byte = block_number_ff[15:8];
         HDR_NUMBER_LO: hdr_byte = block_number_ff[7:0];
         HDR_TOTAL_HI:  hdr_byte = 8'(block_total_ff[CAP_W-1:8]);
         HDR_TOTAL_LO:  hdr_byte = block_total_ff[7:0];
         HDR_FILL_HI:   hdr_byte = fill_word[15:8];
         HDR_FILL_LO:   hdr_byte = fill_word[7:0];
         default:       hdr_byte = 8'h00;
      endcase
   end

   // Data item bookkeeping.
   assign fill_inc   = fill_ff + 1'b1;
   assign remain_dec = (remaining_ff != '0) ? (remaining_ff - 1'b1) : remaining_ff;
   assign report_due = (fill_inc == FILL_W'(PAYLOAD_LEN)) || (remain_dec == '0);

   // Report count check for a start item.
   assign cap      = (max_blocks_ff > hrs_pkg::CAP_LIMIT) ? hrs_pkg::CAP_LIMIT : max_blocks_ff;
   assign dividend = NUM_W'(req_message_length) + NUM_W'(PAYLOAD_LEN - 1);
   assign too_many = blocks > NUM_W'(cap);

   hrs_divider #(
      .NUM_W   (NUM_W),
      .DIVISOR (PAYLOAD_LEN)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept && (req_command == hrs_pkg::CMD_START)),
      .dividend (dividend),
      .done     (div_done),
      .quotient (blocks)
   );

   // Payload buffer: writes happen only while idle and reads only while a report streams,
   // after its header bytes, so the read port never needs forwarding.
   assign mem_write = req_accept && (req_command == hrs_pkg::CMD_DATA) && open_ff;
   assign mem_read  = issue && use_mem;

   always_ff @(posedge clock) begin
      if (mem_write) begin
         payload_mem[fill_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      if (mem_read) begin
         rd_data_ff <= payload_mem[pay_idx[ADDR_W-1:0]];
      end
   end

   // Control state, read stage and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_blocks_ff   <= hrs_pkg::CAP_LIMIT;
         fill_ff         <= '0;
         block_number_ff <= '0;
         block_total_ff  <= '0;
         remaining_ff    <= '0;
         open_ff         <= 1'b0;
         idx_ff          <= '0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_blocks_ff <= csr_write_data;
         end

         // The output register takes a report byte or a pending status item.
         if (out_free) begin
            if (b_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= hrs_pkg::KIND_REPORT;
               rsp_status_ff <= hrs_pkg::STATUS_OK;
               rsp_byte_ff   <= b_use_mem_ff ? rd_data_ff : b_hdr_ff;
               rsp_last_ff   <= b_last_ff;
            end else if (state_ff == ST_STATUS) begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= hrs_pkg::KIND_STATUS;
               rsp_status_ff <= pend_status_ff;
               rsp_byte_ff   <= 8'h00;
               rsp_last_ff   <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
            b_valid_ff <= state_ff == ST_EMIT;
            if (state_ff == ST_EMIT) begin
               b_use_mem_ff <= use_mem;
               b_last_ff    <= last_idx;
               b_hdr_ff     <= hdr_byte;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_command == hrs_pkg::CMD_START) begin
                     fill_ff         <= '0;
                     block_number_ff <= '0;
                     open_ff         <= 1'b0;
                     length_ff       <= req_message_length;
                     state_ff        <= ST_DIVIDE;
                  end else if (!open_ff) begin
                     pend_status_ff <= hrs_pkg::STATUS_NO_MESSAGE;
                     state_ff       <= ST_STATUS;
                  end else begin
                     fill_ff      <= fill_inc;
                     remaining_ff <= remain_dec;
                     if (report_due) begin
                        state_ff <= ST_EMIT;
                     end
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  if (length_ff == '0) begin
                     pend_status_ff <= hrs_pkg::STATUS_ZERO_LENGTH;
                  end else if (too_many) begin
                     pend_status_ff <= hrs_pkg::STATUS_TOO_MANY;
                  end else begin
                     pend_status_ff <= hrs_pkg::STATUS_OK;
                     block_total_ff <= blocks[CAP_W-1:0];
                     remaining_ff   <= length_ff;
                     open_ff        <= 1'b1;
                  end
                  state_ff <= ST_STATUS;
               end
            end
            ST_STATUS: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (issue) begin
                  if (last_idx) begin
                     idx_ff          <= '0;
                     block_number_ff <= block_number_ff + 1'b1;
                     fill_ff         <= '0;
                     if (remaining_ff == '0) begin
                        open_ff <= 1'b0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_report_byte    = rsp_byte_ff;
   assign rsp_last_of_report = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A status item never carries report byte content.
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == hrs_pkg::KIND_STATUS)) |->
      (!rsp_last_of_report && (rsp_report_byte == 8'h00)))
      else $error("status item carries report content");

   // A report is only streamed for an open message.
   a_emit_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> open_ff)
      else $error("report streamed without an open message");

   // The fill position never passes the buffer size.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(PAYLOAD_LEN))
      else $error("fill position out of range");

   // The divider finishes only while a start item waits for it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside of a start item");

   // The read stage is filled only by report streaming.
   a_stage_source: assert property (@(posedge clock) disable iff (reset)
      $rose(b_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("read stage loaded outside of a report");
`endif

endmodule

`default_nettype wire

[tb/hid_report_splitter_core_tb.sv]
// Self-checking testbench for the HID report splitter core with directed and random message traffic.
module hid_report_splitter_core_tb;

   localparam int PAYLOAD_LEN = hrs_pkg::PAYLOAD_LEN_DEFAULT;
   localparam int RANDOM_ITEMS = 320;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int LARGEST_MESSAGE = 256 * PAYLOAD_LEN;

   // One result item as the block presents it.
   typedef struct packed {
      hrs_pkg::kind_type   kind;
      hrs_pkg::status_type status;
      logic [7:0]          value;
      logic                last;
   } splitter_result_type;

   // Receiver behavior, switched to a random mode at random intervals.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN_FLIP,
      READY_RARE_STALL
   } stall_mode_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = 1'b0;
   logic [hrs_pkg::LENGTH_W-1:0] req_message_length = '0;
   logic [7:0]                   req_data_byte = 8'd0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_kind;
   logic [1:0]                   rsp_status;
   logic [7:0]                   rsp_report_byte;
   logic                         rsp_last_of_report;
   logic                         csr_write_enable = 1'b0;
   logic [hrs_pkg::CAP_W-1:0]    csr_write_data = '0;

   // Expected results in arrival order.
   splitter_result_type due_results[$];

   // Predictor copy of the block state and its capacity register.
   logic [7:0]                payload_copy[PAYLOAD_LEN];
   logic [5:0]                fill_level = '0;
   logic [15:0]               block_index = '0;
   logic [8:0]                block_count = '0;
   logic [15:0]               bytes_left = '0;
   logic                      msg_open = 1'b0;
   logic [hrs_pkg::CAP_W-1:0] capacity = hrs_pkg::CAP_LIMIT;

   // Run statistics.
   int unsigned items_sent = 0;
   int unsigned messages_opened = 0;
   int unsigned reports_due = 0;
   int unsigned status_due = 0;
   int unsigned capacity_writes = 0;
   int unsigned results_checked = 0;
   int unsigned failures = 0;
   int unsigned burst_left = 0;

   stall_mode_type stall_mode = READY_ALWAYS;
   int unsigned stall_phase = 0;

   hid_report_splitter_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_message_length (req_message_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_report_byte    (rsp_report_byte),
      .rsp_last_of_report (rsp_last_of_report),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   // Queues one status result.
   task automatic push_status(hrs_pkg::status_type code);
      splitter_result_type r;
      r.kind = hrs_pkg::KIND_STATUS;
      r.status = code;
      r.value = 8'd0;
      r.last = 1'b0;
      due_results.push_back(r);
      status_due++;
   endtask

   // Works out the results that one accepted item causes and updates the state copy.
   task automatic predict_split(hrs_pkg::command_type cmd, logic [15:0] len,
                                logic [7:0] data);
      int unsigned blocks;
      int unsigned cap;
      logic [47:0] header;
      splitter_result_type r;
      if (cmd == hrs_pkg::CMD_START) begin
         cap = (capacity > hrs_pkg::CAP_LIMIT) ? 32'(hrs_pkg::CAP_LIMIT) : 32'(capacity);
         blocks = (32'(len) + PAYLOAD_LEN - 1) / PAYLOAD_LEN;
         fill_level = '0;
         block_index = '0;
         msg_open = 1'b0;
         if (len == 16'd0) begin
            push_status(hrs_pkg::STATUS_ZERO_LENGTH);
         end else if (blocks > cap) begin
            push_status(hrs_pkg::STATUS_TOO_MANY);
         end else begin
            block_count = blocks[8:0];
            bytes_left = len;
            msg_open = 1'b1;
            messages_opened++;
            push_status(hrs_pkg::STATUS_OK);
         end
      end else if (!msg_open) begin
         push_status(hrs_pkg::STATUS_NO_MESSAGE);
      end else begin
         payload_copy[fill_level] = data;
         fill_level++;
         if (bytes_left != 16'd0) begin
            bytes_left--;
         end
         // A full buffer or the last message byte sends one report.
         if (fill_level == PAYLOAD_LEN || bytes_left == 16'd0) begin
            header = {block_index, 7'd0, block_count, 10'd0, fill_level};
            r.kind = hrs_pkg::KIND_REPORT;
            r.status = hrs_pkg::STATUS_OK;
            for (int i = 0; i < hrs_pkg::HEADER_LEN; i++) begin
               r.value = header[47 - 8 * i -: 8];
               r.last = 1'b0;
               due_results.push_back(r);
            end
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
               r.value = (i < fill_level) ? payload_copy[i] : 8'd0;
               r.last = (i == PAYLOAD_LEN - 1);
               due_results.push_back(r);
            end
            reports_due++;
            block_index++;
            fill_level = '0;
            if (bytes_left == 16'd0) begin
               msg_open = 1'b0;
            end
         end
      end
   endtask

   // Offers one item, sender gaps included, and predicts it once accepted.
   task automatic send_item(hrs_pkg::command_type cmd, logic [15:0] len, logic [7:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_command <= cmd;
      req_message_length <= len;
      req_data_byte <= data;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_split(cmd, len, data);
      items_sent++;
      @(negedge clock);
   endtask

   // Holds the sender until every expected result has come and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the capacity register once the block is idle.
   task automatic write_capacity(logic [hrs_pkg::CAP_W-1:0] value);
      wait_idle();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      capacity = value;
      capacity_writes++;
      @(negedge clock);
   endtask

   // Opens a message and, if it was taken, delivers the given number of random bytes.
   task automatic send_message(logic [15:0] len, int unsigned byte_count);
      send_item(hrs_pkg::CMD_START, len, 8'($urandom));
      if (msg_open) begin
         repeat (byte_count) send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
      end
   endtask

   // Picks a message length, mostly short, with full and just-over-full blocks.
   function automatic logic [15:0] pick_length();
      logic [15:0] len;
      case ($urandom_range(0, 9))
         0: len = 16'(PAYLOAD_LEN * $urandom_range(1, 2));
         1: len = 16'(PAYLOAD_LEN * $urandom_range(1, 2) + 1);
         2: len = 16'($urandom_range(120, 200));
         default: len = 16'($urandom_range(1, 57));
      endcase
      return len;
   endfunction

   // Data with nothing open is refused.
   task automatic test_no_message();
      send_item(hrs_pkg::CMD_DATA, 16'hFFFF, 8'hFF);
   endtask

   // A zero length start is refused.
   task automatic test_zero_length();
      send_item(hrs_pkg::CMD_START, 16'd0, 8'h00);
   endtask

   // A short message gives one padded report with the byte extremes.
   task automatic test_short_message();
      send_item(hrs_pkg::CMD_START, 16'd3, 8'h00);
      send_item(hrs_pkg::CMD_DATA, 16'h0000, 8'h00);
      send_item(hrs_pkg::CMD_DATA, 16'hFFFF, 8'hFF);
      send_item(hrs_pkg::CMD_DATA, 16'h5A5A, 8'hA5);
   endtask

   // A start during an open message drops the partial message.
   task automatic test_restart();
      send_item(hrs_pkg::CMD_START, 16'd10, 8'($urandom));
      send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
      send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
      send_item(hrs_pkg::CMD_START, 16'd1, 8'($urandom));
      send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
   endtask

   // Capacity zero, one, above the limit, and back to the reset value.
   task automatic test_capacity();
      write_capacity(9'd0);
      send_item(hrs_pkg::CMD_START, 16'd1, 8'($urandom));
      send_item(hrs_pkg::CMD_START, 16'd0, 8'($urandom));
      write_capacity(9'd1);
      send_item(hrs_pkg::CMD_START, 16'(PAYLOAD_LEN), 8'($urandom));
      send_item(hrs_pkg::CMD_START, 16'(PAYLOAD_LEN + 1), 8'($urandom));
      send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
      write_capacity(9'd511);
      send_item(hrs_pkg::CMD_START, 16'hFFFF, 8'($urandom));
      send_item(hrs_pkg::CMD_START, 16'(LARGEST_MESSAGE), 8'($urandom));
      send_item(hrs_pkg::CMD_START, 16'(LARGEST_MESSAGE + 1), 8'($urandom));
      write_capacity(hrs_pkg::CAP_LIMIT);
   endtask

   // The largest message puts a total of 256 in the header; it is cut short after a while.
   task automatic test_largest_message();
      send_message(16'(LARGEST_MESSAGE), PAYLOAD_LEN + $urandom_range(1, 20));
      send_item(hrs_pkg::CMD_START, 16'd0, 8'($urandom));
   endtask

   // Mostly complete messages with random content, plus broken and stray traffic.
   task automatic test_random_traffic();
      int unsigned first_item;
      int unsigned next_write;
      int unsigned choice;
      logic [15:0] len;
      first_item = items_sent;
      next_write = items_sent + $urandom_range(50, 100);
      while (items_sent < first_item + RANDOM_ITEMS) begin
         if (items_sent >= next_write) begin
            case ($urandom_range(0, 4))
               0: write_capacity(9'($urandom_range(0, 511)));
               1: write_capacity(9'd511);
               2: write_capacity(hrs_pkg::CAP_LIMIT);
               default: write_capacity(9'($urandom_range(3, 300)));
            endcase
            next_write = items_sent + $urandom_range(50, 100);
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_idle();
         end
         choice = $urandom_range(0, 99);
         if (choice < 65) begin
            len = pick_length();
            send_message(len, 32'(len));
         end else if (choice < 75) begin
            len = 16'($urandom_range(2, 150));
            send_message(len, $urandom_range(1, 32'(len) - 1));
         end else if (choice < 85) begin
            repeat ($urandom_range(1, 3)) begin
               send_item(hrs_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
            end
         end else if (choice < 93) begin
            send_item(hrs_pkg::CMD_START, 16'($urandom), 8'($urandom));
         end else begin
            send_item(hrs_pkg::CMD_START, 16'd0, 8'($urandom));
         end
      end
   endtask

   // Receiver ready pattern, switching between modes.
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         stall_phase <= $urandom_range(100, 300);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         READY_ALWAYS:    rsp_ready <= 1'b1;
         READY_COIN_FLIP: rsp_ready <= 1'($urandom_range(0, 1));
         default:         rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      splitter_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (due_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: unexpected result kind %0d status %0d byte %02h last %0d",
                        rsp_kind, rsp_status, rsp_report_byte, rsp_last_of_report);
            end
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind || rsp_status !== want.status ||
                rsp_report_byte !== want.value || rsp_last_of_report !== want.last) begin
               failures++;
               if (failures <= 10) begin
                  $display("ERROR: result %0d expected kind %0d status %0d byte %02h last %0d",
                           results_checked, want.kind, want.status, want.value, want.last);
                  $display("       got kind %0d status %0d byte %02h last %0d",
                           rsp_kind, rsp_status, rsp_report_byte, rsp_last_of_report);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_no_message();
      test_zero_length();
      test_short_message();
      test_restart();
      test_capacity();
      test_largest_message();
      test_random_traffic();
      wait_idle();
      $display("Sent %0d items: %0d messages opened, %0d reports, %0d status results.",
               items_sent, messages_opened, reports_due, status_due);
      $display("Checked %0d results over %0d capacity settings, %0d failures.",
               results_checked, capacity_writes, failures);
      if (failures == 0 && due_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timed out with %0d results still due.", due_results.size());
      $display("simulation failed");
      $finish;
   end

endmodule
